[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/cpt_pkg.sv]
`default_nettype none

package cpt_pkg;

    // Quarter-wave table depth (power of two) and coefficient fraction bits
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int COEF_BITS        = 16;

    localparam int IN_W  = 16;
    localparam int OUT_W = 18;

    // Table entries reach 2^COEF_BITS, so one extra bit
    localparam int TAB_W  = COEF_BITS + 1;
    // Signed sine/cosine
    localparam int TRIG_W = COEF_BITS + 2;
    // Angle index: quadrant plus offset
    localparam int R_W    = $clog2(SINE_TABLE_DEPTH);
    localparam int P_W    = R_W + 2;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

    // Divide by three: floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for x < 2^19
    localparam int DIV3_SHIFT = 19;
    localparam logic [17:0] DIV3_MUL = 18'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

    typedef logic [TAB_W-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

    // Integer square root, bit by bit (elaboration only)
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = x;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (bitv > rem)
            begin
                bitv = bitv >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (bitv != 64'd0)
            begin
                if (rem >= res + bitv)
                begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // Unsigned quotient by shift and subtract (elaboration only)
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = 64'd0;
        rem = 65'd0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // round(2^COEF_BITS / sqrt(3))
    localparam logic [COEF_BITS-1:0] INV_SQRT3 = COEF_BITS'(
        (isqrt64((64'd1 << (2 * COEF_BITS + 2)) / 64'd3) + 64'd1) >> 1);

    // Quarter-wave sine table from a Q30 Taylor series
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t          tab;
        logic [63:0]        u;
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        den;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            u    = (64'(k) << 30) >> R_W;
            x    = (u * HALF_PI_Q30) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 12; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                den  = 64'(2 * n) * 64'(2 * n + 1);
                term = udiv64(term, den);
                if ((n % 2) == 1)
                begin
                    sum = sum - $signed(term);
                end
                else
                begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0)
            begin
                sum = 64'sd0;
            end
            tab[k] = TAB_W'(($unsigned(sum) + (64'd1 << (29 - COEF_BITS)))
                            >> (30 - COEF_BITS));
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    // Clamp to the output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > 64'(OUT_MAX))
        begin
            r = OUT_MAX;
        end
        else if (v < 64'(OUT_MIN))
        begin
            r = OUT_MIN;
        end
        else
        begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/clarke_park_transform_unit.sv]
// Throughput: one item per cycle; busy is always low, the six register stages
// (two multiplier ranks among them) set the latency.
// Reset: rst_n clears all stage valid bits; no done until a new item enters.
// The receiver cannot stall; each result shows for exactly one cycle with done.
`default_nettype none

`include "assert_macros.svh"

module clarke_park_transform_unit
    import cpt_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [IN_W-1:0]   phase_a,
    input  wire logic signed [IN_W-1:0]   phase_b,
    input  wire logic signed [IN_W-1:0]   phase_c,
    input  wire logic        [IN_W-1:0]   rotor_angle,
    output logic                          done,
    output logic signed [OUT_W-1:0]       alpha_current,
    output logic signed [OUT_W-1:0]       beta_current,
    output logic signed [OUT_W-1:0]       direct_current,
    output logic signed [OUT_W-1:0]       quadrature_current
);

    localparam int LATENCY = 6;
    localparam int BP_W    = COEF_BITS + 18;   // beta product
    localparam int PR_W    = OUT_W + TRIG_W;   // rotation product
    localparam int SUM_W   = PR_W + 1;
    localparam logic signed [BP_W:0]  B_HALF = (BP_W+1)'(64'd1 << (COEF_BITS - 1));
    localparam logic signed [SUM_W:0] S_HALF = (SUM_W+1)'(64'd1 << (COEF_BITS - 1));

    // Stage valid bits
    logic [LATENCY-1:0] vld_reg;
    logic               take;

    // Stage 1 registers
    logic              neg1_reg;
    logic [17:0]       nmag1_reg;
    logic signed [16:0] diff1_reg;
    logic [1:0]        quad1_reg;
    logic [TAB_W-1:0]  tr1_reg;
    logic [TAB_W-1:0]  tc1_reg;

    // Stage 2 registers
    logic              neg2_reg;
    logic [35:0]       a3prod2_reg;
    logic signed [BP_W-1:0] bprod2_reg;
    logic signed [TRIG_W-1:0] sn2_reg;
    logic signed [TRIG_W-1:0] cs2_reg;

    // Stage 3 registers
    logic signed [OUT_W-1:0]  alpha3_reg;
    logic signed [OUT_W-1:0]  beta3_reg;
    logic signed [TRIG_W-1:0] sn3_reg;
    logic signed [TRIG_W-1:0] cs3_reg;

    // Stage 4 registers
    logic signed [OUT_W-1:0] alpha4_reg;
    logic signed [OUT_W-1:0] beta4_reg;
    logic signed [PR_W-1:0]  p_ac4_reg;
    logic signed [PR_W-1:0]  p_bs4_reg;
    logic signed [PR_W-1:0]  p_bc4_reg;
    logic signed [PR_W-1:0]  p_as4_reg;

    // Stage 5 registers
    logic signed [OUT_W-1:0] alpha5_reg;
    logic signed [OUT_W-1:0] beta5_reg;
    logic signed [SUM_W-1:0] dsum5_reg;
    logic signed [SUM_W-1:0] qsum5_reg;

    // Stage 6 (output) registers
    logic signed [OUT_W-1:0] alpha6_reg;
    logic signed [OUT_W-1:0] beta6_reg;
    logic signed [OUT_W-1:0] d6_reg;
    logic signed [OUT_W-1:0] q6_reg;

    // Next values
    logic signed [18:0]      num_next;
    logic signed [18:0]      nabs_next;
    logic [17:0]             nmag1_next;
    logic signed [16:0]      diff1_next;
    logic [P_W-1:0]          p_next;
    logic [R_W-1:0]          r_next;
    logic [R_W:0]            rc_next;
    logic signed [TRIG_W-1:0] tr_s;
    logic signed [TRIG_W-1:0] tc_s;
    logic signed [TRIG_W-1:0] sn2_next;
    logic signed [TRIG_W-1:0] cs2_next;
    logic [16:0]             amag3_next;
    logic signed [OUT_W-1:0] alpha3_next;
    logic signed [BP_W:0]    bround3_next;
    logic signed [SUM_W:0]   dround6_next;
    logic signed [SUM_W:0]   qround6_next;

    assign busy = 1'b0;
    assign take = start && !busy;

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], take};
        end
    end

    // Stage 1: Clarke sums, angle split and table lookups
    always_comb
    begin
        num_next   = (19'(phase_a) <<< 1) - 19'(phase_b) - 19'(phase_c);
        nabs_next  = num_next[18] ? -num_next : num_next;
        nmag1_next = nabs_next[17:0] + 18'd1;
        diff1_next = 17'(phase_b) - 17'(phase_c);
        p_next     = rotor_angle[IN_W-1 -: P_W];
        r_next     = p_next[R_W-1:0];
        rc_next    = (R_W+1)'(SINE_TABLE_DEPTH) - {1'b0, r_next};
    end

    always_ff @(posedge clk)
    begin
        neg1_reg  <= num_next[18];
        nmag1_reg <= nmag1_next;
        diff1_reg <= diff1_next;
        quad1_reg <= p_next[P_W-1 -: 2];
        tr1_reg   <= SINE_TAB[{1'b0, r_next}];
        tc1_reg   <= SINE_TAB[rc_next];
    end

    // Stage 2: divide-by-three and beta multiplies, quadrant signs
    always_comb
    begin
        tr_s = $signed({1'b0, tr1_reg});
        tc_s = $signed({1'b0, tc1_reg});
        case (quad1_reg)
            2'd0:
            begin
                sn2_next = tr_s;
                cs2_next = tc_s;
            end
            2'd1:
            begin
                sn2_next = tc_s;
                cs2_next = -tr_s;
            end
            2'd2:
            begin
                sn2_next = -tr_s;
                cs2_next = -tc_s;
            end
            default:
            begin
                sn2_next = -tc_s;
                cs2_next = tr_s;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        neg2_reg    <= neg1_reg;
        a3prod2_reg <= 36'(nmag1_reg) * 36'(DIV3_MUL);
        bprod2_reg  <= BP_W'(diff1_reg) * BP_W'($signed({1'b0, INV_SQRT3}));
        sn2_reg     <= sn2_next;
        cs2_reg     <= cs2_next;
    end

    // Stage 3: alpha sign restore, beta rounding (ties away from zero) and saturation
    always_comb
    begin
        amag3_next   = a3prod2_reg[DIV3_SHIFT +: 17];
        alpha3_next  = neg2_reg ? -$signed({1'b0, amag3_next})
                                :  $signed({1'b0, amag3_next});
        bround3_next = ((BP_W+1)'(bprod2_reg)
                        + (bprod2_reg[BP_W-1] ? B_HALF - 1 : B_HALF)) >>> COEF_BITS;
    end

    always_ff @(posedge clk)
    begin
        alpha3_reg <= alpha3_next;
        beta3_reg  <= sat_out(64'(bround3_next));
        sn3_reg    <= sn2_reg;
        cs3_reg    <= cs2_reg;
    end

    // Stage 4: Park rotation products
    always_ff @(posedge clk)
    begin
        alpha4_reg <= alpha3_reg;
        beta4_reg  <= beta3_reg;
        p_ac4_reg  <= PR_W'(alpha3_reg) * PR_W'(cs3_reg);
        p_bs4_reg  <= PR_W'(beta3_reg) * PR_W'(sn3_reg);
        p_bc4_reg  <= PR_W'(beta3_reg) * PR_W'(cs3_reg);
        p_as4_reg  <= PR_W'(alpha3_reg) * PR_W'(sn3_reg);
    end

    // Stage 5: product sums
    always_ff @(posedge clk)
    begin
        alpha5_reg <= alpha4_reg;
        beta5_reg  <= beta4_reg;
        dsum5_reg  <= SUM_W'(p_ac4_reg) + SUM_W'(p_bs4_reg);
        qsum5_reg  <= SUM_W'(p_bc4_reg) - SUM_W'(p_as4_reg);
    end

    // Stage 6: round, saturate, output register
    always_comb
    begin
        dround6_next = ((SUM_W+1)'(dsum5_reg)
                        + (dsum5_reg[SUM_W-1] ? S_HALF - 1 : S_HALF)) >>> COEF_BITS;
        qround6_next = ((SUM_W+1)'(qsum5_reg)
                        + (qsum5_reg[SUM_W-1] ? S_HALF - 1 : S_HALF)) >>> COEF_BITS;
    end

    always_ff @(posedge clk)
    begin
        alpha6_reg <= alpha5_reg;
        beta6_reg  <= beta5_reg;
        d6_reg     <= sat_out(64'(dround6_next));
        q6_reg     <= sat_out(64'(qround6_next));
    end

    assign done               = vld_reg[LATENCY-1];
    assign alpha_current      = alpha6_reg;
    assign beta_current       = beta6_reg;
    assign direct_current     = d6_reg;
    assign quadrature_current = q6_reg;

    // Every done traces back to an item taken at the pipeline input
    `AST_IMPLY(a_done_has_item, done, $past(take, LATENCY))
    // An item taken always comes out with done
    `AST_IMPLY(a_item_comes_out, take, ##LATENCY done)
    // A negative alpha only comes from a negative Clarke numerator
    `AST_NEXT(a_alpha_sign, vld_reg[1] && !neg2_reg, !alpha3_reg[OUT_W-1])

endmodule

`default_nettype wire
